FILE: rtl/c16alu_pkg.sv
// Package for the 16-bit ALU with status flags: operation codes, flag
// positions, state encoding and small helper functions. No dependencies.
package c16alu_pkg;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_ADC = 5'd1, OP_SUB = 5'd2, OP_SBB = 5'd3,
        OP_AND = 5'd4, OP_OR = 5'd5, OP_XOR = 5'd6, OP_INC = 5'd7,
        OP_DEC = 5'd8, OP_NEG = 5'd9, OP_NOT = 5'd10, OP_MULU = 5'd11,
        OP_MULI = 5'd12, OP_DIVU = 5'd13, OP_DIVI = 5'd14, OP_RCL = 5'd15,
        OP_RCR = 5'd16, OP_ROL = 5'd17, OP_ROR = 5'd18, OP_SAL = 5'd19,
        OP_SAR = 5'd20, OP_SHL = 5'd21, OP_SHR = 5'd22
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIX  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam int FL_CY = 0;
    localparam int FL_P  = 1;
    localparam int FL_AC = 2;
    localparam int FL_Z  = 3;
    localparam int FL_S  = 4;
    localparam int FL_V  = 5;

    function automatic logic even_par(input logic [7:0] v);
        even_par = ~(^v);
    endfunction

endpackage

FILE: rtl/cpu16_alu_with_status_flags.sv
// Top level of the 8/16-bit ALU with six stored status flags.
// Uses c16alu_pkg for op codes, flag positions and state encoding.
//
// Rate: one operation at a time. An item is taken while idle and runs its
// operation in the next cycle; the result then sits in the output
// register until transferred. RCL and RCR use one shared rotate step per
// unit of count (up to 31 steps) plus a closing step that writes the flags.
// Divides run a restoring shift-subtract unit, one quotient bit per cycle
// (8 or 16 steps) plus a sign fix-up step; a zero divisor skips the unit.
module cpu16_alu_with_status_flags
    import c16alu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_op,
    input  logic        i_word_size,
    input  logic [31:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result,
    output logic        o_divide_error,
    output logic        o_carry_out,
    output logic        o_parity_out,
    output logic        o_aux_carry_out,
    output logic        o_zero_out,
    output logic        o_sign_out,
    output logic        o_overflow_out
);

    t_state      r_state, n_state;
    logic [5:0]  r_flags, n_flags;
    logic [4:0]  r_op;
    logic        r_ws;
    logic [31:0] r_a;
    logic [15:0] r_b;
    logic [31:0] r_res, n_res;
    logic        r_derr, n_derr;
    // shared iteration registers
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_rot, n_rot;   // rotate value / quotient
    logic        r_rcy, n_rcy;   // rotate carry
    logic [16:0] r_rem, n_rem;   // partial remainder
    logic [15:0] r_dvd, n_dvd;   // dividend low bits still to shift in
    logic [15:0] r_dvs, n_dvs;   // divisor magnitude
    logic        r_qneg, n_qneg, r_rneg, n_rneg;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_result = r_res;
    assign o_divide_error = r_derr;
    assign o_carry_out = r_flags[FL_CY];
    assign o_parity_out = r_flags[FL_P];
    assign o_aux_carry_out = r_flags[FL_AC];
    assign o_zero_out = r_flags[FL_Z];
    assign o_sign_out = r_flags[FL_S];
    assign o_overflow_out = r_flags[FL_V];

    // width-dependent values
    logic [15:0] m, sg, x, y;
    logic [4:0]  bits, c5;
    logic [3:0]  c4;
    logic [31:0] dd;
    assign m    = r_ws ? 16'hffff : 16'h00ff;
    assign sg   = r_ws ? 16'h8000 : 16'h0080;
    assign bits = r_ws ? 5'd16 : 5'd8;
    assign x    = r_a[15:0] & m;
    assign y    = r_b & m;
    assign c5   = r_b[4:0];
    assign c4   = r_b[3:0];
    assign dd   = r_ws ? r_a : {16'd0, r_a[15:0]};

    logic xneg, yneg, dneg;
    assign xneg = |(x & sg);
    assign yneg = |(y & sg);
    assign dneg = r_ws ? r_a[31] : r_a[15];

    function automatic logic [5:0] pzs(input logic [5:0] f, input logic [15:0] r,
                                       input logic [15:0] s);
        logic [5:0] g;
        g = f;
        g[FL_P] = even_par(r[7:0]);
        g[FL_Z] = (r == 16'd0);
        g[FL_S] = |(r & s);
        return g;
    endfunction

    // combinational datapath
    logic [16:0] sum;
    logic [4:0]  nib;
    logic [15:0] r16;
    logic [31:0] prod_u;
    logic signed [31:0] prod_s;
    logic signed [15:0] sx, sy;
    logic [31:0] wsh;
    logic [15:0] sar_r;
    logic [3:0]  rot;
    logic [31:0] rdbl;
    logic        ci;
    logic        fits;
    // divide step
    logic [16:0] trial;
    logic [15:0] quo_mag, rem_mag;
    logic [16:0] qv;
    logic [15:0] qs, rs;

    always_comb begin
        n_state = r_state;
        n_flags = r_flags;
        n_res   = r_res;
        n_derr  = r_derr;
        n_cnt   = r_cnt;
        n_rot   = r_rot;
        n_rcy   = r_rcy;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_dvs   = r_dvs;
        n_qneg  = r_qneg;
        n_rneg  = r_rneg;
        ci = 1'b0; sum = '0; nib = '0; r16 = '0; fits = 1'b0;
        prod_u = {16'd0, x} * {16'd0, y};
        sx = r_ws ? $signed(x) : $signed({{8{x[7]}}, x[7:0]});
        sy = r_ws ? $signed(y) : $signed({{8{y[7]}}, y[7:0]});
        prod_s = sx * sy;
        wsh = {16'd0, x} << c5;
        sar_r = '0;
        rot = r_ws ? c4 : {1'b0, c4[2:0]};
        rdbl = '0;
        trial = r_rem - {1'b0, r_dvs};
        quo_mag = '0; rem_mag = '0; qv = '0; qs = '0; rs = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_derr  = 1'b0;
                n_state = S_OUT;
                case (r_op)
                    OP_ADD, OP_ADC: begin
                        ci  = (r_op == OP_ADC) & r_flags[FL_CY];
                        sum = {1'b0, x} + {1'b0, y} + {16'd0, ci};
                        r16 = sum[15:0] & m;
                        nib = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, ci};
                        n_flags[FL_CY] = r_ws ? sum[16] : sum[8];
                        n_flags[FL_AC] = nib[4];
                        n_flags = pzs(n_flags, r16, sg);
                        n_flags[FL_V] = |((r16 ^ x) & (r16 ^ y) & sg);
                        n_res = {16'd0, r16};
                    end
                    OP_SUB, OP_SBB: begin
                        ci  = (r_op == OP_SBB) & r_flags[FL_CY];
                        sum = {1'b0, x} - {1'b0, y} - {16'd0, ci};
                        r16 = sum[15:0] & m;
                        nib = {1'b0, x[3:0]} - {1'b0, y[3:0]} - {4'd0, ci};
                        n_flags[FL_CY] = sum[16];
                        n_flags[FL_AC] = nib[4];
                        n_flags = pzs(n_flags, r16, sg);
                        n_flags[FL_V] = |((x ^ y) & (x ^ r16) & sg);
                        n_res = {16'd0, r16};
                    end
                    OP_AND, OP_OR, OP_XOR: begin
                        r16 = (r_op == OP_AND) ? (x & y) :
                              (r_op == OP_OR) ? (x | y) : (x ^ y);
                        n_flags[FL_CY] = 1'b0;
                        n_flags[FL_AC] = 1'b0;
                        n_flags = pzs(n_flags, r16, sg);
                        n_flags[FL_V] = 1'b0;
                        n_res = {16'd0, r16};
                    end
                    OP_INC: begin
                        r16 = (x + 16'd1) & m;
                        n_flags[FL_AC] = (x[3:0] == 4'hf);
                        n_flags = pzs(n_flags, r16, sg);
                        n_flags[FL_V] = (r16 == sg);
                        n_res = {16'd0, r16};
                    end
                    OP_DEC: begin
                        r16 = (x - 16'd1) & m;
                        n_flags[FL_AC] = (x[3:0] == 4'h0);
                        n_flags = pzs(n_flags, r16, sg);
                        n_flags[FL_V] = (r16 == sg - 16'd1);
                        n_res = {16'd0, r16};
                    end
                    OP_NEG: begin
                        r16 = (16'd0 - x) & m;
                        n_flags[FL_CY] = (x != 16'd0);
                        n_flags[FL_AC] = (x[3:0] != 4'h0);
                        n_flags = pzs(n_flags, r16, sg);
                        n_flags[FL_V] = (x == sg);
                        n_res = {16'd0, r16};
                    end
                    OP_NOT: n_res = {16'd0, ~x & m};
                    OP_MULU: begin
                        fits = r_ws ? (prod_u[31:16] == 16'd0) : (prod_u[15:8] == 8'd0);
                        n_flags[FL_CY] = ~fits;
                        n_flags[FL_V]  = ~fits;
                        n_res = prod_u;
                    end
                    OP_MULI: begin
                        fits = r_ws ? (prod_s[31:15] == {17{prod_s[15]}})
                                    : (prod_s[31:7] == {25{prod_s[7]}});
                        n_flags[FL_CY] = ~fits;
                        n_flags[FL_V]  = ~fits;
                        n_res = r_ws ? prod_s : {16'd0, prod_s[15:0]};
                    end
                    OP_DIVU, OP_DIVI: begin
                        // load magnitudes; the high half is the start remainder
                        n_qneg = (r_op == OP_DIVI) & (dneg ^ yneg);
                        n_rneg = (r_op == OP_DIVI) & dneg;
                        n_dvs  = ((r_op == OP_DIVI) & yneg) ? ((16'd0 - y) & m) : y;
                        if ((r_op == OP_DIVI) & dneg) begin
                            rdbl = (32'd0 - dd) & (r_ws ? 32'hffffffff : 32'h0000ffff);
                        end else begin
                            rdbl = dd;
                        end
                        n_rem = 17'd0;
                        n_dvd = r_ws ? rdbl[15:0] : {rdbl[7:0], 8'd0};
                        // remainder register starts with the top W bits
                        n_rem[15:0] = r_ws ? rdbl[31:16] : {8'd0, rdbl[15:8]};
                        n_rot = '0;
                        n_cnt = bits;
                        if (y == 16'd0) begin
                            n_res = dd; n_derr = 1'b1;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                    OP_RCL, OP_RCR: begin
                        n_rot = x;
                        n_rcy = r_flags[FL_CY];
                        n_cnt = c5;
                        n_state = S_DIV;
                    end
                    OP_ROL: begin
                        rdbl = r_ws ? ({16'd0, x} << rot) : ({24'd0, x[7:0]} << rot);
                        r16 = r_ws ? (rdbl[15:0] | rdbl[31:16]) : {8'd0, rdbl[7:0] | rdbl[15:8]};
                        n_flags[FL_CY] = (c4 != 4'd0) & r16[0];
                        n_flags[FL_V]  = |((x ^ r16) & sg);
                        n_res = {16'd0, r16};
                    end
                    OP_ROR: begin
                        rdbl = r_ws ? ({x, 16'd0} >> rot) : ({16'd0, x[7:0], 8'd0} >> rot);
                        r16 = r_ws ? (rdbl[15:0] | rdbl[31:16]) : {8'd0, rdbl[7:0] | rdbl[15:8]};
                        if (c4 == 4'd0) begin
                            n_res = {16'd0, x};
                        end else begin
                            n_flags[FL_CY] = |(r16 & sg);
                            n_flags[FL_V]  = |((x ^ r16) & sg);
                            n_res = {16'd0, r16};
                        end
                    end
                    OP_SAL, OP_SHL: begin
                        r16 = wsh[15:0] & m;
                        n_flags[FL_CY] = r_ws ? wsh[16] : wsh[8];
                        n_flags = pzs(n_flags, r16, sg);
                        n_flags[FL_V] = (r_op == OP_SHL) & (|((x ^ r16) & sg));
                        n_res = {16'd0, r16};
                    end
                    OP_SAR: begin
                        rdbl  = {{16{xneg}}, (r_ws ? x : {{8{xneg}}, x[7:0]})};
                        rdbl  = $signed(rdbl) >>> c5;
                        sar_r = rdbl[15:0] & m;
                        if (c5 == 5'd0) begin
                            n_res = {16'd0, x};
                        end else if (c5[4]) begin
                            n_flags[FL_CY] = xneg;
                            n_res = {16'd0, xneg ? m : 16'd0};
                        end else begin
                            if (c5 >= bits) n_flags[FL_CY] = xneg;
                            else n_flags[FL_CY] = x[c5[3:0] - 4'd1];
                            n_flags = pzs(n_flags, sar_r, sg);
                            n_flags[FL_V] = 1'b0;
                            n_res = {16'd0, sar_r};
                        end
                    end
                    OP_SHR: begin
                        r16 = x >> c5;
                        if (c5 == 5'd0) begin
                            n_res = {16'd0, x};
                        end else begin
                            n_flags[FL_CY] = (c5 > 5'd16) ? 1'b0 : x[c5[3:0] - 4'd1];
                            n_flags = pzs(n_flags, r16, sg);
                            n_flags[FL_V] = |((x ^ r16) & sg);
                            n_res = {16'd0, r16};
                        end
                    end
                    default: n_res = '0;
                endcase
            end
            S_DIV: begin
                if (r_op == OP_RCL || r_op == OP_RCR) begin
                    if (r_cnt == 5'd0) begin
                        n_flags[FL_CY] = r_rcy;
                        n_flags[FL_V]  = |((x ^ r_rot) & sg);
                        n_res = {16'd0, r_rot};
                        n_state = S_OUT;
                    end else begin
                        // one rotate-through-carry step
                        if (r_op == OP_RCL) begin
                            n_rcy = |(r_rot & sg);
                            n_rot = {r_rot[14:0], r_rcy} & m;
                        end else begin
                            n_rcy = r_rot[0];
                            n_rot = (r_rcy ? sg : 16'd0) | (r_rot >> 1);
                        end
                        n_cnt = r_cnt - 5'd1;
                    end
                end else begin
                    // one restoring quotient step
                    trial = {r_rem[15:0], r_dvd[15]} - {1'b0, r_dvs};
                    n_dvd = {r_dvd[14:0], 1'b0};
                    if (!trial[16] || r_rem[16] || r_rem[15]) begin
                        n_rem = trial;
                        n_rem[16] = 1'b0;
                        n_rot = {r_rot[14:0], 1'b1};
                        // quotient bit beyond W bits means overflow
                        if (r_cnt == bits && (r_rem[15:0] >= r_dvs)) n_derr = 1'b1;
                    end else begin
                        n_rem = {r_rem[15:0], r_dvd[15]};
                        n_rot = {r_rot[14:0], 1'b0};
                    end
                    if (r_cnt == bits) begin
                        n_derr = ((r_rem[15:0] & m) >= r_dvs);
                    end
                    n_cnt = r_cnt - 5'd1;
                    if (r_cnt == 5'd1) n_state = S_FIX;
                end
            end
            S_FIX: begin
                quo_mag = r_rot & m;
                rem_mag = r_rem[15:0] & m;
                qs = r_qneg ? ((16'd0 - quo_mag) & m) : quo_mag;
                rs = r_rneg ? ((16'd0 - rem_mag) & m) : rem_mag;
                // range check: magnitude limit depends on sign for signed divide
                if (r_op == OP_DIVI) begin
                    qv = {1'b0, quo_mag};
                    if (r_qneg) fits = (qv <= {1'b0, sg});
                    else fits = (qv < {1'b0, sg});
                end else begin
                    fits = 1'b1;
                end
                if (r_derr || !fits) begin
                    n_res = dd; n_derr = 1'b1;
                end else begin
                    n_res = r_ws ? {rs, qs} : {16'd0, rs[7:0], qs[7:0]};
                    n_derr = 1'b0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
        end
    end

    // payload: capture on transfer, advance otherwise
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op <= i_op;
            r_ws <= i_word_size;
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
        end
        r_res  <= n_res;
        r_derr <= n_derr;
        r_cnt  <= n_cnt;
        r_rot  <= n_rot;
        r_rcy  <= n_rcy;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_dvs  <= n_dvs;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

endmodule
